/* rtl/hrhs_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP response head scanner package
// Word types, scan state, character constants and the reset state shared by
// the scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhs_pkg;

  // One input word: a byte of the response head and its restart flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_word_t;

  // One result word, produced for every input byte.
  typedef struct packed {
    logic       status_ready;
    logic [9:0] status_code;
    logic       malformed;
    logic       legacy_response;
    logic       head_done;
  } out_word_t;

  // Phases of the status line scan.
  typedef enum logic [2:0] {
    PhPrefix = 3'd0,
    PhSlash  = 3'd1,
    PhVmaj   = 3'd2,
    PhVmin   = 3'd3,
    PhSpace  = 3'd4,
    PhDigits = 3'd5,
    PhDone   = 3'd6
  } phase_e;

  // Scan state carried from one byte to the next.
  typedef struct packed {
    phase_e     phase;
    logic [2:0] prefix_idx;
    logic [9:0] code;
    logic [1:0] digit_count;
    logic       after_nl;
    logic       after_nl_cr;
    logic       finished;
  } scan_state_t;

  localparam scan_state_t StateReset = '{
    phase:       PhPrefix,
    prefix_idx:  3'd0,
    code:        10'd0,
    digit_count: 2'd0,
    after_nl:    1'b0,
    after_nl_cr: 1'b0,
    finished:    1'b0
  };

  // Character codes.
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChReturn  = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChVtabLow = 8'h09;
  localparam logic [7:0] ChCrHigh  = 8'h0D;

  // Status reported for a response without the protocol prefix.
  localparam logic [9:0] CodeLegacy = 10'd200;

  // Expected byte of the "HTTP" prefix at a given position.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h48;
      2'd1:    ch = 8'h54;
      2'd2:    ch = 8'h54;
      default: ch = 8'h50;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/hrhs_scan_step.sv */
// ----------------------------------------------------------------------------
// HTTP response head scan step
// Combinational next-state and result logic for one byte of the head.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhs_scan_step (
  input  var hrhs_pkg::scan_state_t state_i,
  input  var hrhs_pkg::in_word_t    in_word_i,
  output hrhs_pkg::scan_state_t     state_o,
  output hrhs_pkg::out_word_t       out_word_o
);

  hrhs_pkg::scan_state_t s;
  hrhs_pkg::scan_state_t n;
  hrhs_pkg::out_word_t   res;
  logic [7:0]            b;
  logic                  b_digit;
  logic                  b_space;
  logic                  b_blank;
  logic                  skip_phase;
  logic                  taken;
  logic [13:0]           acc_wide;
  logic [1:0]            cnt_inc;

  assign b       = in_word_i.data_byte;
  assign b_digit = (b >= hrhs_pkg::ChZero) && (b <= hrhs_pkg::ChNine);
  assign b_space = (b == hrhs_pkg::ChSpace) ||
                   ((b >= hrhs_pkg::ChVtabLow) && (b <= hrhs_pkg::ChCrHigh));
  assign b_blank = (b == hrhs_pkg::ChSpace) || (b == hrhs_pkg::ChTab);

  // Restart clears the state before the byte is scanned.
  assign s = in_word_i.restart ? hrhs_pkg::StateReset : state_i;

  // Status code accumulation: code * 10 + digit, kept to ten bits.
  assign acc_wide = ({4'd0, s.code} << 3) + ({4'd0, s.code} << 1) + {10'd0, b[3:0]};
  assign cnt_inc  = s.digit_count + 2'd1;

  // Phase machine for one byte.
  always_comb begin
    n          = s;
    res        = '0;
    skip_phase = 1'b0;
    taken      = 1'b0;
    if (!s.finished) begin
      case (s.phase)
        hrhs_pkg::PhPrefix: begin
          if (b == hrhs_pkg::magic_byte(s.prefix_idx[1:0])) begin
            n.prefix_idx = s.prefix_idx + 3'd1;
            if (s.prefix_idx == 3'd3) begin
              n.phase = hrhs_pkg::PhSlash;
            end
          end else begin
            res.status_ready    = 1'b1;
            res.status_code     = hrhs_pkg::CodeLegacy;
            res.legacy_response = 1'b1;
            res.head_done       = 1'b1;
            n.finished          = 1'b1;
            n.phase             = hrhs_pkg::PhDone;
          end
        end
        hrhs_pkg::PhDigits: begin
          if (b_digit) begin
            n.code        = acc_wide[9:0];
            n.digit_count = cnt_inc;
            if (cnt_inc == 2'd3) begin
              res.status_ready = 1'b1;
              res.status_code  = acc_wide[9:0];
              n.phase          = hrhs_pkg::PhDone;
            end
          end else begin
            res.malformed = 1'b1;
            n.phase       = hrhs_pkg::PhDone;
          end
        end
        hrhs_pkg::PhSlash: begin
          skip_phase = 1'b1;
          if (b == hrhs_pkg::ChSlash) begin
            n.phase = hrhs_pkg::PhVmaj;
            taken   = 1'b1;
          end else begin
            n.phase = hrhs_pkg::PhSpace;
          end
        end
        hrhs_pkg::PhVmaj: begin
          skip_phase = 1'b1;
          if (b_digit) begin
            taken = 1'b1;
          end else if (b == hrhs_pkg::ChDot) begin
            n.phase = hrhs_pkg::PhVmin;
            taken   = 1'b1;
          end else begin
            n.phase = hrhs_pkg::PhSpace;
          end
        end
        hrhs_pkg::PhVmin: begin
          skip_phase = 1'b1;
          if (b_digit) begin
            taken = 1'b1;
          end else begin
            n.phase = hrhs_pkg::PhSpace;
          end
        end
        hrhs_pkg::PhSpace: begin
          skip_phase = 1'b1;
        end
        default: begin
        end
      endcase

      // Whitespace skipping ahead of the status digits.
      if (skip_phase && !taken) begin
        if (s.after_nl && !b_blank) begin
          res.malformed = 1'b1;
          n.phase       = hrhs_pkg::PhDone;
        end else if (b_space) begin
          n.phase = n.phase;
        end else if (b_digit) begin
          n.code        = {6'd0, b[3:0]};
          n.digit_count = 2'd1;
          n.phase       = hrhs_pkg::PhDigits;
        end else begin
          res.malformed = 1'b1;
          n.phase       = hrhs_pkg::PhDone;
        end
      end

      // End of head detection on a blank line.
      if (!n.finished) begin
        if ((b == hrhs_pkg::ChNewline) && (s.after_nl || s.after_nl_cr)) begin
          res.head_done = 1'b1;
          n.finished    = 1'b1;
        end
        n.after_nl_cr = s.after_nl && (b == hrhs_pkg::ChReturn);
        n.after_nl    = (b == hrhs_pkg::ChNewline);
      end
    end
  end

  assign state_o    = n;
  assign out_word_o = res;

endmodule

`default_nettype wire

/* rtl/http_response_head_scanner_unit.sv */
// ----------------------------------------------------------------------------
// HTTP response head scanner unit
// Scans an HTTP response head one byte per word and reports status and end.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of the response head per word, with
//   a restart flag set on the first byte of each response. The output
//   channel returns exactly one result word for every input word, in order.
//   Both channels use valid and stall; a word moves when valid is high and
//   stall is low.
// Registers and throughput:
//   A byte is accepted into the input register, and its result is loaded
//   from there into the output register once that register is free. One
//   byte is taken every cycle while the receiver does not stall; the scan
//   state update is combinational between the input and result registers.
// Reset and stalls:
//   Reset empties both registers and returns the scan state to the start of
//   a response, so the first byte after reset begins a new response. While
//   the receiver stalls a full result register, the pipeline holds, and the
//   input stalls once the input register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_head_scanner_unit (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                in_valid_i,
  output logic                    in_stall_o,
  input  var hrhs_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  var logic                out_stall_i,
  output hrhs_pkg::out_word_t     out_word_o
);

  logic                  in_valid_q;
  hrhs_pkg::in_word_t    in_word_q;
  logic                  out_valid_q;
  hrhs_pkg::out_word_t   out_word_q;
  hrhs_pkg::out_word_t   out_word_d;
  hrhs_pkg::scan_state_t state_q;
  hrhs_pkg::scan_state_t state_d;
  logic                  advance;
  logic                  in_load;

  // Pipeline control: the result register frees when it is empty or taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  // Scan logic between the input register and the result register.
  hrhs_scan_step u_step (
    .state_i    (state_q),
    .in_word_i  (in_word_q),
    .state_o    (state_d),
    .out_word_o (out_word_d)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= hrhs_pkg::StateReset;
    end else begin
      if (advance) begin
        in_valid_q  <= in_load;
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end else if (in_load) begin
        in_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_word_q <= in_word_i;
    end
    if (advance && in_valid_q) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A legacy response reports status 200 and ends the head on the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.legacy_response |->
      out_word_o.status_ready && out_word_o.head_done &&
      (out_word_o.status_code == hrhs_pkg::CodeLegacy))
    else $error("legacy result without status 200 and head end");

  // The status code is zero unless a status is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.status_ready |-> (out_word_o.status_code == 10'd0))
    else $error("status code set without status ready");

  // A word never reports both a status and a malformed line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.status_ready && out_word_o.malformed))
    else $error("status ready and malformed in one word");

  // The input stalls only when both registers are occupied and blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // Scan state changes only when a byte moves into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_valid_q) |=> $stable(state_q))
    else $error("scan state changed without a byte");

endmodule

`default_nettype wire

/* tb/sv/tb_http_response_head_scanner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response head scanner unit testbench
// Feeds response heads byte by byte: a short table of hand-picked bytes,
// then random responses that are mostly well formed with broken ones and
// noise mixed in. Result words are checked against typed table answers
// or a scan predictor kept in step with the accepted bytes. Sender and
// receiver pacing change from phase to phase, and one phase holds the
// output off long enough to back the block up into its input.
// ----------------------------------------------------------------------------

module tb_http_response_head_scanner_unit;

  // Pacing of the two channels.
  typedef enum int {
    ModeFree,
    ModeSrcIdle,
    ModeSinkStall,
    ModeBoth,
    ModeHold
  } pace_e;

  // One byte to send, with a hand-written answer where one is typed in.
  typedef struct {
    hrhs_pkg::in_word_t  w;
    bit                  typed;
    hrhs_pkg::out_word_t ans;
  } stim_t;

  // One row of the directed table.
  typedef struct packed {
    logic [7:0]          b;
    logic                rs;
    logic                typed;
    hrhs_pkg::out_word_t ans;
  } row_t;

  localparam logic [31:0] HttpMagic = "HTTP";
  localparam logic [7:0]  ChVtab    = 8'h0B;
  localparam logic [7:0]  ChFeed    = 8'h0C;
  localparam int          RandPerPhase = 240;
  localparam int          HoldCycles   = 300;

  localparam hrhs_pkg::out_word_t AnsIdle   = '0;
  localparam hrhs_pkg::out_word_t AnsLegacy = '{status_ready: 1'b1,
                                                status_code: hrhs_pkg::CodeLegacy,
                                                malformed: 1'b0, legacy_response: 1'b1,
                                                head_done: 1'b1};
  localparam hrhs_pkg::out_word_t AnsTop    = '{status_ready: 1'b1, status_code: 10'd999,
                                                malformed: 1'b0, legacy_response: 1'b0,
                                                head_done: 1'b0};
  localparam hrhs_pkg::out_word_t AnsBad    = '{status_ready: 1'b0, status_code: 10'd0,
                                                malformed: 1'b1, legacy_response: 1'b0,
                                                head_done: 1'b0};
  localparam hrhs_pkg::out_word_t AnsDone   = '{status_ready: 1'b0, status_code: 10'd0,
                                                malformed: 1'b0, legacy_response: 1'b0,
                                                head_done: 1'b1};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  hrhs_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hrhs_pkg::out_word_t out_word_o;

  // Scan state of the predictor.
  hrhs_pkg::phase_e scan_phase;
  logic [2:0]       matched;
  logic [9:0]       code_acc;
  logic [1:0]       digits_seen;
  bit               nl_seen;
  bit               nl_cr_seen;
  bit               head_over;

  stim_t               head_bytes[$];
  hrhs_pkg::out_word_t predicted_words[$];
  row_t                dir_table[27];
  pace_e               src_mode  = ModeFree;
  pace_e               sink_mode = ModeFree;
  pace_e               last_sink_mode = ModeFree;
  int                  hold_left = 0;
  int                  fail_count = 0;
  int                  scanned;

  http_response_head_scanner_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] magic_at(input int idx);
    return HttpMagic[31 - 8 * idx -: 8];
  endfunction

  function automatic bit is_digit_ch(input logic [7:0] b);
    return b >= hrhs_pkg::ChZero && b <= hrhs_pkg::ChNine;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == hrhs_pkg::ChSpace || (b >= hrhs_pkg::ChTab && b <= hrhs_pkg::ChReturn);
  endfunction

  function automatic void clear_scan();
    scan_phase  = hrhs_pkg::PhPrefix;
    matched     = 3'd0;
    code_acc    = 10'd0;
    digits_seen = 2'd0;
    nl_seen     = 1'b0;
    nl_cr_seen  = 1'b0;
    head_over   = 1'b0;
  endfunction

  // Advances the predicted scan state by one byte and returns its result.
  function automatic hrhs_pkg::out_word_t scan_byte(input hrhs_pkg::in_word_t w);
    hrhs_pkg::out_word_t r;
    logic [7:0]          b;
    bit                  consumed;
    bit                  is_nl;
    r = '0;
    b = w.data_byte;
    consumed = 1'b0;
    if (w.restart) clear_scan();
    if (!head_over) begin
      case (scan_phase)
        hrhs_pkg::PhPrefix: begin
          if (b == magic_at(matched)) begin
            matched = matched + 3'd1;
            if (matched == 3'd4) scan_phase = hrhs_pkg::PhSlash;
          end else begin
            r.status_ready    = 1'b1;
            r.status_code     = hrhs_pkg::CodeLegacy;
            r.legacy_response = 1'b1;
            r.head_done       = 1'b1;
            head_over         = 1'b1;
            scan_phase        = hrhs_pkg::PhDone;
          end
        end
        hrhs_pkg::PhDigits: begin
          if (is_digit_ch(b)) begin
            code_acc    = code_acc * 10'd10 + 10'(b - hrhs_pkg::ChZero);
            digits_seen = digits_seen + 2'd1;
            if (digits_seen == 2'd3) begin
              r.status_ready = 1'b1;
              r.status_code  = code_acc;
              scan_phase     = hrhs_pkg::PhDone;
            end
          end else begin
            r.malformed = 1'b1;
            scan_phase  = hrhs_pkg::PhDone;
          end
        end
        hrhs_pkg::PhSlash, hrhs_pkg::PhVmaj, hrhs_pkg::PhVmin, hrhs_pkg::PhSpace: begin
          // The optional version is eaten first; whatever it rejects is
          // judged as the gap before the code.
          if (scan_phase == hrhs_pkg::PhSlash) begin
            if (b == hrhs_pkg::ChSlash) begin
              scan_phase = hrhs_pkg::PhVmaj;
              consumed   = 1'b1;
            end else begin
              scan_phase = hrhs_pkg::PhSpace;
            end
          end else if (scan_phase == hrhs_pkg::PhVmaj) begin
            if (is_digit_ch(b)) begin
              consumed = 1'b1;
            end else if (b == hrhs_pkg::ChDot) begin
              scan_phase = hrhs_pkg::PhVmin;
              consumed   = 1'b1;
            end else begin
              scan_phase = hrhs_pkg::PhSpace;
            end
          end else if (scan_phase == hrhs_pkg::PhVmin) begin
            if (is_digit_ch(b)) consumed = 1'b1;
            else scan_phase = hrhs_pkg::PhSpace;
          end
          if (!consumed) begin
            if (nl_seen && b != hrhs_pkg::ChSpace && b != hrhs_pkg::ChTab) begin
              r.malformed = 1'b1;
              scan_phase  = hrhs_pkg::PhDone;
            end else if (is_blank(b)) begin
              // Still in the gap before the code.
            end else if (is_digit_ch(b)) begin
              code_acc    = 10'(b - hrhs_pkg::ChZero);
              digits_seen = 2'd1;
              scan_phase  = hrhs_pkg::PhDigits;
            end else begin
              r.malformed = 1'b1;
              scan_phase  = hrhs_pkg::PhDone;
            end
          end
        end
        default: begin
        end
      endcase
      // Track the blank line that ends the head.
      if (!head_over) begin
        is_nl = (b == hrhs_pkg::ChNewline);
        if (is_nl && (nl_seen || nl_cr_seen)) begin
          r.head_done = 1'b1;
          head_over   = 1'b1;
        end
        nl_cr_seen = nl_seen && b == hrhs_pkg::ChReturn;
        nl_seen    = is_nl;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_text();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] rand_digit();
    return hrhs_pkg::ChZero + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(4))
      0:       return hrhs_pkg::ChSpace;
      1:       return hrhs_pkg::ChTab;
      2:       return ChVtab;
      3:       return ChFeed;
      default: return hrhs_pkg::ChReturn;
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic rs);
    stim_t s;
    s.w.data_byte = b;
    s.w.restart   = rs;
    s.typed       = 1'b0;
    s.ans         = AnsIdle;
    head_bytes.push_back(s);
  endtask

  // Builds one random response head and queues its bytes.
  task automatic build_response();
    logic [7:0] bq[$];
    int         kind;
    int         n;
    int         bad_pos;
    int         cut;
    logic [7:0] ch;
    kind = $urandom_range(99);
    if (kind < 12) begin
      // Prefix that breaks off early.
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) bq.push_back(magic_at(i));
      ch = 8'($urandom_range(255));
      if (ch == magic_at(n)) ch = ch ^ 8'h20;
      bq.push_back(ch);
    end else if (kind < 22) begin
      n = $urandom_range(4, 20);
      for (int i = 0; i < n; i++) bq.push_back(8'($urandom_range(255)));
    end else begin
      for (int i = 0; i < 4; i++) bq.push_back(magic_at(i));
      if ($urandom_range(3) != 0) begin
        bq.push_back(hrhs_pkg::ChSlash);
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) bq.push_back(rand_digit());
        if ($urandom_range(1) != 0) begin
          bq.push_back(hrhs_pkg::ChDot);
          n = $urandom_range(2);
          for (int i = 0; i < n; i++) bq.push_back(rand_digit());
        end
        bq.push_back(hrhs_pkg::ChSpace);
      end
      n = $urandom_range(2);
      for (int i = 0; i < n; i++) bq.push_back(rand_blank());
      // Folded line, or a line that ends before the code.
      case ($urandom_range(9))
        0: begin
          bq.push_back(hrhs_pkg::ChNewline);
          bq.push_back(hrhs_pkg::ChSpace);
        end
        1: begin
          bq.push_back(hrhs_pkg::ChNewline);
          bq.push_back(hrhs_pkg::ChTab);
        end
        2:       bq.push_back(hrhs_pkg::ChNewline);
        default: begin
        end
      endcase
      // Status code, now and then with a wrong or broken character.
      n = $urandom_range(9);
      bad_pos = (n == 0) ? 0 : (n == 1) ? $urandom_range(1, 2) : 3;
      for (int i = 0; i < 3; i++) begin
        if (i == bad_pos) bq.push_back(8'($urandom_range(255)));
        else bq.push_back(rand_digit());
      end
      n = $urandom_range(8);
      for (int i = 0; i < n; i++) bq.push_back(rand_text());
      n = $urandom_range(2);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(1) != 0) bq.push_back(hrhs_pkg::ChReturn);
        bq.push_back(hrhs_pkg::ChNewline);
        cut = $urandom_range(1, 10);
        for (int j = 0; j < cut; j++) bq.push_back(rand_text());
      end
      case ($urandom_range(2))
        0: begin
          bq.push_back(hrhs_pkg::ChNewline);
          bq.push_back(hrhs_pkg::ChNewline);
        end
        1: begin
          bq.push_back(hrhs_pkg::ChReturn);
          bq.push_back(hrhs_pkg::ChNewline);
          bq.push_back(hrhs_pkg::ChReturn);
          bq.push_back(hrhs_pkg::ChNewline);
        end
        default: begin
          bq.push_back(hrhs_pkg::ChNewline);
          bq.push_back(hrhs_pkg::ChReturn);
          bq.push_back(hrhs_pkg::ChNewline);
        end
      endcase
      // Sometimes the next response starts before this one ends.
      if ($urandom_range(9) == 0) begin
        cut = $urandom_range(1, bq.size() - 1);
        while (bq.size() > cut) void'(bq.pop_back());
      end
    end
    scanned += bq.size();
    foreach (bq[i]) begin
      queue_byte(bq[i], (i == 0) || (kind >= 12 && kind < 22 && $urandom_range(7) == 0));
    end
    // Bytes past the end of the head.
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(255)), 1'b0);
  endtask

  function automatic bit src_gap();
    case (src_mode)
      ModeSrcIdle: return $urandom_range(99) < 70;
      ModeBoth:    return $urandom_range(99) < 30;
      default:     return 1'b0;
    endcase
  endfunction

  // Offers one word, called at a falling edge, returns at a falling edge.
  task automatic send_word(input stim_t s);
    hrhs_pkg::out_word_t pred;
    while (src_gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= s.w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = scan_byte(s.w);
    predicted_words.push_back(s.typed ? s.ans : pred);
    @(negedge clk_i);
  endtask

  task automatic send_queued();
    @(negedge clk_i);
    while (head_bytes.size() != 0) send_word(head_bytes.pop_front());
    in_valid_i <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [9:0] want,
                             input logic [9:0] got);
    if (got !== want) begin
      note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  // Receiver pacing; a long hold-off opens the hold phase.
  always @(negedge clk_i) begin
    if (sink_mode != last_sink_mode) begin
      last_sink_mode = sink_mode;
      hold_left = (sink_mode == ModeHold) ? HoldCycles : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (sink_mode)
        ModeSinkStall: out_stall_i <= ($urandom_range(99) < 70);
        ModeBoth:      out_stall_i <= ($urandom_range(99) < 30);
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin : result_check
    hrhs_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_words.size() == 0) begin
        note_failure($sformatf("unexpected word %h", out_word_o));
      end else begin
        want = predicted_words.pop_front();
        check_field("status_ready", want.status_ready, out_word_o.status_ready);
        check_field("status_code", want.status_code, out_word_o.status_code);
        check_field("malformed", want.malformed, out_word_o.malformed);
        check_field("legacy_response", want.legacy_response,
                    out_word_o.legacy_response);
        check_field("head_done", want.head_done, out_word_o.head_done);
      end
    end
  end

  initial begin
    stim_t s;
    // Directed bytes: a first byte without restart, a full head with the
    // top code and a CR LF CR LF end, a folded line with broken digits, then a legacy restart.
    dir_table = '{
      '{"X", 1'b0, 1'b1, AnsLegacy},
      '{8'hFF, 1'b0, 1'b1, AnsIdle},
      '{"H", 1'b1, 1'b0, AnsIdle},
      '{"T", 1'b0, 1'b0, AnsIdle},
      '{"T", 1'b0, 1'b0, AnsIdle},
      '{"P", 1'b0, 1'b0, AnsIdle},
      '{"/", 1'b0, 1'b0, AnsIdle},
      '{"1", 1'b0, 1'b0, AnsIdle},
      '{".", 1'b0, 1'b0, AnsIdle},
      '{"0", 1'b0, 1'b0, AnsIdle},
      '{" ", 1'b0, 1'b0, AnsIdle},
      '{"9", 1'b0, 1'b0, AnsIdle},
      '{"9", 1'b0, 1'b0, AnsIdle},
      '{"9", 1'b0, 1'b1, AnsTop},
      '{hrhs_pkg::ChReturn, 1'b0, 1'b0, AnsIdle},
      '{hrhs_pkg::ChNewline, 1'b0, 1'b0, AnsIdle},
      '{hrhs_pkg::ChReturn, 1'b0, 1'b0, AnsIdle},
      '{hrhs_pkg::ChNewline, 1'b0, 1'b1, AnsDone},
      '{"H", 1'b1, 1'b0, AnsIdle},
      '{"T", 1'b0, 1'b0, AnsIdle},
      '{"T", 1'b0, 1'b0, AnsIdle},
      '{"P", 1'b0, 1'b0, AnsIdle},
      '{hrhs_pkg::ChNewline, 1'b0, 1'b0, AnsIdle},
      '{hrhs_pkg::ChSpace, 1'b0, 1'b0, AnsIdle},
      '{"1", 1'b0, 1'b0, AnsIdle},
      '{hrhs_pkg::ChNewline, 1'b0, 1'b1, AnsBad},
      '{8'h00, 1'b1, 1'b1, AnsLegacy}
    };
    clear_scan();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      s.w.data_byte = dir_table[i].b;
      s.w.restart   = dir_table[i].rs;
      s.typed       = dir_table[i].typed;
      s.ans         = dir_table[i].ans;
      head_bytes.push_back(s);
    end
    send_queued();

    // Random responses under each pacing.
    for (int m = ModeFree; m <= ModeHold; m++) begin
      src_mode  = pace_e'(m);
      sink_mode = pace_e'(m);
      scanned = 0;
      while (scanned < RandPerPhase) build_response();
      send_queued();
    end

    repeat (8) @(posedge clk_i);
    if (predicted_words.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", predicted_words.size()));
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
